FILE: src/cbs_pkg.sv
package cbs_pkg;

    localparam int IDX_W    = 7;
    localparam int LEN_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int SPEED_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [SPEED_W-1:0] SPEED_FAST = 10'd800;
    localparam logic [SPEED_W-1:0] SPEED_SLOW = 10'd560;
    localparam logic [SPEED_W-1:0] SPEED_STOP = 10'd0;

    localparam logic [1:0] VERDICT_SIGHT   = 2'd0;
    localparam logic [1:0] VERDICT_REACHED = 2'd1;
    localparam logic [1:0] VERDICT_NONE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RED_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SIZE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_HIGH = 3'd7;

    typedef struct packed {
        logic [15:0] pixel_word;
        logic        last_pixel;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         verdict;
        logic [BYTE_W-1:0]  blob_size;
        logic [BYTE_W-1:0]  blob_position;
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
    } out_word_t;

    typedef struct packed {
        logic [4:0] red_low;
        logic [5:0] red_high;
        logic [5:0] green_low;
        logic [6:0] green_high;
        logic [5:0] blue_high;
        logic [7:0] stop_size;
        logic [7:0] centre_low;
        logic [7:0] centre_high;
    } cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [IDX_W-1:0] start;
    } blob_t;

endpackage

FILE: src/color_blob_steering_core.sv
// Color blob steering: classifies RGB565 pixel words against the red and green
// windows and the blue upper bound and tracks the longest matching run of the
// scan line. A last_pixel word yields one result word (size and center of the
// best run in bytes, verdict, wheel speeds) via the input and output registers;
// other words yield nothing. One word is taken every cycle unless a last pixel
// waits on a held result word; the run tracker updates its line state from the
// input register, cleared after each last pixel. Configuration writes are taken
// at any time through cfg_valid/cfg_ready and should be made while idle.
module color_blob_steering_core #(
    parameter int LINE_PIXELS = 80
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cbs_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cbs_pkg::out_word_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cbs_pkg::*;

    cfg_t      cfg_reg;
    logic      s1_valid_reg, s1_valid_next;
    in_word_t  s1_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg;

    logic      out_free;
    logic      advance;
    logic      accept;
    logic      hit;
    blob_t     best;
    out_word_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_low     <= 5'd10;
            cfg_reg.red_high    <= 6'd20;
            cfg_reg.green_low   <= 6'd35;
            cfg_reg.green_high  <= 7'd45;
            cfg_reg.blue_high   <= 6'd32;
            cfg_reg.stop_size   <= 8'd140;
            cfg_reg.centre_low  <= 8'd76;
            cfg_reg.centre_high <= 8'd84;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RED_LOW:     cfg_reg.red_low     <= cfg_data[4:0];
                REG_RED_HIGH:    cfg_reg.red_high    <= cfg_data[5:0];
                REG_GREEN_LOW:   cfg_reg.green_low   <= cfg_data[5:0];
                REG_GREEN_HIGH:  cfg_reg.green_high  <= cfg_data[6:0];
                REG_BLUE_HIGH:   cfg_reg.blue_high   <= cfg_data[5:0];
                REG_STOP_SIZE:   cfg_reg.stop_size   <= cfg_data;
                REG_CENTRE_LOW:  cfg_reg.centre_low  <= cfg_data;
                REG_CENTRE_HIGH: cfg_reg.centre_high <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // a last pixel waits only when a result word is still held downstream
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!s1_word_reg.last_pixel || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (advance && s1_word_reg.last_pixel)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= in_data;
        end
        if (advance && s1_word_reg.last_pixel)
        begin
            out_word_reg <= result;
        end
    end

    cbs_match u_match (
        .pixel_word (s1_word_reg.pixel_word),
        .cfg        (cfg_reg),
        .hit        (hit)
    );

    cbs_run_track #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_run_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .hit        (hit),
        .last_pixel (s1_word_reg.last_pixel),
        .best       (best)
    );

    cbs_steer u_steer (
        .best   (best),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

FILE: src/cbs_match.sv
module cbs_match (
    input  logic [15:0]  pixel_word,
    input  cbs_pkg::cfg_t cfg,
    output logic         hit
);
    import cbs_pkg::*;

    logic [4:0] red;
    logic [5:0] green;
    logic [4:0] blue;

    assign red   = pixel_word[15:11];
    assign green = pixel_word[10:5];
    assign blue  = pixel_word[4:0];

    assign hit = (red > cfg.red_low)
              && ({1'b0, red} < cfg.red_high)
              && (green > cfg.green_low)
              && ({1'b0, green} < cfg.green_high)
              && ({1'b0, blue} < cfg.blue_high);

endmodule

FILE: src/cbs_run_track.sv
module cbs_run_track #(
    parameter int LINE_PIXELS = 80
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           hit,
    input  logic           last_pixel,
    output cbs_pkg::blob_t best
);
    import cbs_pkg::*;

    localparam logic [IDX_W-1:0] LINE_END = IDX_W'(LINE_PIXELS);

    logic [IDX_W-1:0] pixel_index_reg, pixel_index_next;
    logic             run_active_reg, run_active_next;
    logic [IDX_W-1:0] run_start_reg, run_start_next;
    blob_t            best_reg, best_next;

    logic             in_line;
    logic             open_now;
    logic             close_mid;
    logic             active_mid;
    logic [IDX_W-1:0] index_mid;
    logic             close_any;
    logic [IDX_W-1:0] run_end;
    logic [LEN_W-1:0] run_len;
    logic             take_run;

    always_comb
    begin
        in_line    = pixel_index_reg < LINE_END;
        open_now   = in_line && hit && !run_active_reg;
        close_mid  = in_line && !hit && run_active_reg;
        active_mid = open_now || (run_active_reg && !close_mid);
        index_mid  = in_line ? pixel_index_reg + 1'b1 : pixel_index_reg;
        run_start_next = open_now ? pixel_index_reg : run_start_reg;

        // a run still open on the last pixel closes at the line end
        close_any = close_mid || (last_pixel && active_mid);
        run_end   = close_mid ? pixel_index_reg : index_mid;
        run_len   = (run_end >= run_start_next)
                  ? {1'b0, run_end - run_start_next} : '0;
        take_run  = close_any && (run_len >= LEN_W'(2)) && (run_len > best_reg.length);

        best = best_reg;
        if (take_run)
        begin
            best.length = run_len;
            best.start  = run_start_next;
        end

        if (last_pixel)
        begin
            pixel_index_next = '0;
            run_active_next  = 1'b0;
            best_next        = '0;
            run_start_next   = '0;
        end
        else
        begin
            pixel_index_next = index_mid;
            run_active_next  = active_mid && !close_any;
            best_next        = best;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_index_reg <= '0;
            run_active_reg  <= 1'b0;
            run_start_reg   <= '0;
            best_reg        <= '0;
        end
        else if (advance)
        begin
            pixel_index_reg <= pixel_index_next;
            run_active_reg  <= run_active_next;
            run_start_reg   <= run_start_next;
            best_reg        <= best_next;
        end
    end

endmodule

FILE: src/cbs_steer.sv
module cbs_steer (
    input  cbs_pkg::blob_t     best,
    input  cbs_pkg::cfg_t      cfg,
    output cbs_pkg::out_word_t result
);
    import cbs_pkg::*;

    logic [BYTE_W-1:0] size;
    logic [BYTE_W-1:0] pos;

    always_comb
    begin
        size = {best.length[BYTE_W-2:0], 1'b0};
        pos  = (best.length != '0) ? ({best.start, 1'b0} + best.length) : '0;

        result.blob_size     = size;
        result.blob_position = pos;
        result.left_speed    = SPEED_STOP;
        result.right_speed   = SPEED_STOP;

        if (size > cfg.stop_size)
        begin
            result.verdict = VERDICT_REACHED;
        end
        else if (size != '0)
        begin
            result.verdict = VERDICT_SIGHT;
            if (pos < cfg.centre_low)
            begin
                result.left_speed  = SPEED_FAST;
                result.right_speed = SPEED_SLOW;
            end
            else if (pos > cfg.centre_high)
            begin
                result.left_speed  = SPEED_SLOW;
                result.right_speed = SPEED_FAST;
            end
            else
            begin
                result.left_speed  = SPEED_FAST;
                result.right_speed = SPEED_FAST;
            end
        end
        else
        begin
            result.verdict = VERDICT_NONE;
        end
    end

endmodule
